@@ rtl/core/ifm_pkg.sv @@
`default_nettype none
package ifm_pkg;
   localparam int MaxTransferDefault = 131072;
   localparam int CntW = 18;
   localparam logic [7:0] BaseReset = 8'hA0;

   typedef enum logic [1:0] {ACT_TICK = 2'd0, ACT_START = 2'd1, ACT_DATA = 2'd2,
                             ACT_NONE = 2'd3} action_type;
   typedef enum logic [1:0] {OP_WRITE = 2'd0, OP_READ = 2'd1, OP_ERASE = 2'd2,
                             OP_BAD = 2'd3} op_type;
   typedef enum logic [1:0] {ST_OK = 2'd0, ST_BUSY = 2'd1, ST_NACK = 2'd2,
                             ST_BADDEV = 2'd3} status_type;
   typedef enum logic [3:0] {
      S_IDLE, S_STA_A, S_STA_B, S_STA_C, S_TX_DEV, S_TX_AHI, S_TX_ALO, S_RSTA_A,
      S_RSTA_B, S_RSTA_C, S_TX_DEVR, S_WAIT, S_TX_DATA, S_RX, S_STOP_0, S_STOP_1
   } seq_type;

   typedef struct packed {
      action_type action;
      op_type     op;
      logic [1:0] kind;
      logic [1:0] cs;
      logic [16:0] maddr;
      logic [CntW-1:0] cnt;
      logic [7:0] wbyte;
      logic       sda;
   } req_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic [7:0] rbyte;
      logic rvalid;
      logic need;
      logic busy;
      logic done;
      status_type status;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/core/ifm_stream_if.sv @@
`default_nettype none
interface ifm_stream_if #(parameter int W = 1);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/i2c_fram_transaction_master_top.sv @@
`default_nettype none
// path: a request transfer passes the two-entry queue between front and engine, then the engine response register
// throughput: one request transfer per cycle while the queue has room and the engine can take it
// the engine takes a new transfer only while its response register is empty or is being taken
// reset: synchronous active high, engine idle, base 0xA0
module i2c_fram_transaction_master_top #(
   parameter int MAX_TRANSFER = ifm_pkg::MaxTransferDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   ifm_stream_if.sink   req,
   ifm_stream_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import ifm_pkg::*;
   logic [7:0] base_ff;
   logic fq_valid, fq_ready, qe_valid, qe_ready;
   req_type fq_data, qe_data;
   rsp_type e_out;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr == 2'd0 ? {24'd0, base_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) base_ff <= BaseReset;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         base_ff <= csr_pwdata[7:0];
   end

   ifm_front #(.MAX_TRANSFER(MAX_TRANSFER)) u_front (
      .req, .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));
   ifm_queue #(.W($bits(req_type))) u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(qe_valid), .out_ready(qe_ready), .out_data(qe_data));
   ifm_engine u_engine (
      .clock, .reset, .base(base_ff), .in_valid(qe_valid), .in_ready(qe_ready),
      .in_data(qe_data), .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(e_out));
   assign rsp.data = e_out;
endmodule
`default_nettype wire

@@ rtl/core/ifm_queue.sv @@
`default_nettype none
module ifm_queue #(parameter int W = 8) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic [W-1:0] in_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;
   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/ifm_front.sv @@
`default_nettype none
module ifm_front #(parameter int MAX_TRANSFER = 131072) (
   ifm_stream_if.sink req,
   output logic q_valid,
   input  wire logic q_ready,
   output ifm_pkg::req_type q_data
);
   import ifm_pkg::*;
   req_type r;
   logic [24:0] wide;
   assign r = req_type'(req.data);
   assign req.ready = q_ready;
   assign q_valid = req.valid;
   always_comb begin
      q_data = r;
      wide = {7'd0, r.cnt};
      if (wide > 25'(MAX_TRANSFER)) q_data.cnt = CntW'(MAX_TRANSFER);
   end
endmodule
`default_nettype wire

@@ rtl/core/ifm_engine.sv @@
`default_nettype none
module ifm_engine (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [7:0] base,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire ifm_pkg::req_type in_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output ifm_pkg::rsp_type out_data
);
   import ifm_pkg::*;
   seq_type s_ff, s_in;
   logic ph_ff, ph_in;
   logic [3:0] bi_ff, bi_in;
   logic [7:0] sh_ff, sh_in;
   logic [CntW-1:0] bl_ff, bl_in;
   logic [16:0] ad_ff, ad_in;
   logic [5:0] cmd_ff, cmd_in;
   status_type fs_ff, fs_in;
   logic ov_ff;
   rsp_type o_ff, o_in;
   logic go, istx;
   logic done;
   status_type sto;
   logic rv;
   logic [7:0] rb;
   logic [7:0] devb;
   logic bad;
   logic [16:0] mask;

   assign in_ready = !ov_ff || out_ready;
   assign go = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data = o_ff;
   assign istx = s_ff == S_TX_DEV || s_ff == S_TX_AHI || s_ff == S_TX_ALO ||
                 s_ff == S_TX_DEVR || s_ff == S_TX_DATA;

   always_comb begin
      devb = base;
      unique case (cmd_ff[3:2])
         2'd0: devb[1] = devb[1] | (ad_ff[15:8] != 8'd0);
         2'd3: begin
            devb[3:2] = devb[3:2] | cmd_ff[5:4];
            devb[1] = devb[1] | (ad_ff[16] != 1'b0);
         end
         default: devb[2:1] = devb[2:1] | cmd_ff[5:4];
      endcase
   end

   always_comb begin
      unique case (in_data.kind)
         2'd0: mask = 17'h001FF;
         2'd1: mask = 17'h01FFF;
         2'd2: mask = 17'h07FFF;
         default: mask = 17'h1FFFF;
      endcase
      bad = in_data.op == OP_BAD || (in_data.kind == 2'd0 && in_data.cs != 2'd0) ||
            ((in_data.kind == 2'd1 || in_data.kind == 2'd2) && in_data.cs[1]);
   end

   always_comb begin
      s_in = s_ff; ph_in = ph_ff; bi_in = bi_ff; sh_in = sh_ff; bl_in = bl_ff;
      ad_in = ad_ff; cmd_in = cmd_ff; fs_in = fs_ff;
      done = 1'b0; sto = ST_OK; rv = 1'b0; rb = 8'd0;
      if (in_data.action == ACT_START && s_ff == S_IDLE) begin
         if (in_data.op == OP_READ && in_data.cnt == '0) done = 1'b1;
         else if (bad) begin done = 1'b1; sto = ST_BADDEV; end
         else begin
            cmd_in = {in_data.cs, in_data.kind, in_data.op};
            ad_in = in_data.maddr & mask;
            bl_in = in_data.cnt; fs_in = ST_OK; s_in = S_STA_A;
         end
      end else if (in_data.action == ACT_DATA && s_ff == S_WAIT) begin
         s_in = S_TX_DATA; sh_in = in_data.wbyte; bi_in = 4'd0; ph_in = 1'b0;
      end else if (in_data.action == ACT_TICK) begin
         if (istx || s_ff == S_RX) begin
            if (!ph_ff) ph_in = 1'b1;
            else if (bi_ff < 4'd8) begin
               if (s_ff == S_RX) begin
                  sh_in = {sh_ff[6:0], in_data.sda};
                  if (bi_ff == 4'd7) begin rv = 1'b1; rb = sh_in; end
               end
               bi_in = bi_ff + 4'd1; ph_in = 1'b0;
            end else if (s_ff == S_RX) begin
               if (bl_ff != '0) bl_in = bl_ff - 1'b1;
               if (bl_in == '0) begin fs_in = ST_OK; s_in = S_STOP_0; end
               else begin bi_in = 4'd0; ph_in = 1'b0; sh_in = 8'd0; end
            end else if (in_data.sda) begin
               fs_in = ST_NACK; s_in = S_STOP_0;
            end else begin
               bi_in = 4'd0; ph_in = 1'b0;
               if (s_ff == S_TX_DEV) begin
                  if (cmd_ff[3:2] == 2'd0) begin s_in = S_TX_ALO; sh_in = ad_ff[7:0]; end
                  else begin s_in = S_TX_AHI; sh_in = ad_ff[15:8]; end
               end else if (s_ff == S_TX_AHI) begin
                  s_in = S_TX_ALO; sh_in = ad_ff[7:0];
               end else if (s_ff == S_TX_DEVR) begin
                  s_in = S_RX; sh_in = 8'd0;
               end else if (s_ff == S_TX_ALO && cmd_ff[1:0] == OP_READ) begin
                  s_in = S_RSTA_A;
               end else begin
                  if (s_ff == S_TX_DATA && bl_ff != '0) bl_in = bl_ff - 1'b1;
                  if (bl_in == '0) begin fs_in = ST_OK; s_in = S_STOP_0; end
                  else if (cmd_ff[1:0] == OP_WRITE) s_in = S_WAIT;
                  else begin s_in = S_TX_DATA; sh_in = 8'd0; end
               end
            end
         end else begin
            unique case (s_ff)
               S_STA_A, S_RSTA_A:
                  if (!in_data.sda) begin fs_in = ST_BUSY; s_in = S_STOP_0; end
                  else s_in = seq_type'(s_ff + 4'd1);
               S_STA_B, S_RSTA_B:
                  if (in_data.sda) begin fs_in = ST_BUSY; s_in = S_STOP_0; end
                  else s_in = seq_type'(s_ff + 4'd1);
               S_STA_C: begin s_in = S_TX_DEV; sh_in = devb; bi_in = 4'd0; ph_in = 1'b0; end
               S_RSTA_C: begin
                  s_in = S_TX_DEVR; sh_in = devb | 8'h01; bi_in = 4'd0; ph_in = 1'b0;
               end
               S_STOP_0: s_in = S_STOP_1;
               S_STOP_1: begin s_in = S_IDLE; done = 1'b1; sto = fs_ff; end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      o_in = '0;
      o_in.rbyte = rb; o_in.rvalid = rv; o_in.done = done;
      o_in.status = done ? sto : ST_OK;
      o_in.need = s_in == S_WAIT;
      o_in.busy = s_in != S_IDLE;
      unique case (s_in)
         S_TX_DEV, S_TX_AHI, S_TX_ALO, S_TX_DEVR, S_TX_DATA: begin
            o_in.scl = ph_in;
            o_in.sda = bi_in < 4'd8 ? sh_in[3'(4'd7 - bi_in)] : 1'b1;
         end
         S_RX: begin
            o_in.scl = ph_in;
            o_in.sda = bi_in < 4'd8 ? 1'b1 : (bl_in <= CntW'(1));
         end
         S_STA_B, S_RSTA_B, S_STOP_1: begin o_in.scl = 1'b1; o_in.sda = 1'b0; end
         S_STA_C, S_RSTA_C, S_STOP_0: begin o_in.scl = 1'b0; o_in.sda = 1'b0; end
         S_WAIT: begin o_in.scl = 1'b0; o_in.sda = 1'b1; end
         default: begin o_in.scl = 1'b1; o_in.sda = 1'b1; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (go) o_ff <= o_in;
      if (reset) begin
         s_ff <= S_IDLE; ph_ff <= 1'b0; bi_ff <= 4'd0; sh_ff <= 8'd0; bl_ff <= '0;
         ad_ff <= '0; cmd_ff <= '0; fs_ff <= ST_OK; ov_ff <= 1'b0;
      end else begin
         if (go) begin
            s_ff <= s_in; ph_ff <= ph_in; bi_ff <= bi_in; sh_ff <= sh_in;
            bl_ff <= bl_in; ad_ff <= ad_in; cmd_ff <= cmd_in; fs_ff <= fs_in;
            ov_ff <= 1'b1;
         end else if (out_ready) ov_ff <= 1'b0;
      end
   end

`ifndef NO_ASSERTIONS
   a_bits: assert property (@(posedge clock) disable iff (reset) bi_ff <= 4'd8)
      else $error("bit index overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> $stable(o_ff)) else $error("result changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      ov_ff && o_ff.done |-> !o_ff.busy) else $error("done while busy");
`endif
endmodule
`default_nettype wire

@@ verif/i2c_fram_transaction_master_top_tb.sv @@
`timescale 1ns / 100ps
module i2c_fram_transaction_master_top_tb;
   import ifm_pkg::*;

   localparam int MaxXfer = MaxTransferDefault;
   localparam int StallLimit = 3000;

   typedef enum int {FLT_NONE, FLT_BUSY, FLT_NACK} fault_type;

   class fram_scoreboard;
      rsp_type expected_rsp[$];
      int errors;
      int checked;
      int reads_seen;
      int done_seen;
      logic [7:0] base;
      seq_type st;
      logic [1:0] ph;
      logic [3:0] bi;
      logic [7:0] sh;
      logic [17:0] left;
      logic [16:0] addr;
      logic [5:0] cmd;
      logic scl_d;
      logic sda_d;
      status_type fin;

      function new();
         base = BaseReset;
         st = S_IDLE;
         ph = '0;
         bi = '0;
         sh = '0;
         left = '0;
         addr = '0;
         cmd = '0;
         fin = ST_OK;
         scl_d = 1'b1;
         sda_d = 1'b1;
      endfunction

      function bit sending();
         return st == S_TX_DEV || st == S_TX_AHI || st == S_TX_ALO ||
                st == S_TX_DEVR || st == S_TX_DATA;
      endfunction

      function logic [7:0] device_byte(bit rd);
         logic [7:0] v;
         v = base;
         if (cmd[3:2] == 2'd0) begin
            if (addr[15:8] != 0) v = v | 8'h02;
         end else if (cmd[3:2] == 2'd3) begin
            v = v | {4'd0, cmd[5:4], 2'd0};
            if (addr[16]) v = v | 8'h02;
         end else begin
            v = v | {5'd0, cmd[5:4], 1'b0};
         end
         if (rd) v = v | 8'h01;
         return v;
      endfunction

      function void load_byte(seq_type s, logic [7:0] b);
         st = s;
         sh = b;
         bi = '0;
         ph = '0;
      endfunction

      function void go_stop(status_type s);
         fin = s;
         st = S_STOP_0;
      endfunction

      function void next_data();
         if (left == 0) go_stop(ST_OK);
         else if (op_type'(cmd[1:0]) == OP_WRITE) st = S_WAIT;
         else load_byte(S_TX_DATA, 8'h00);
      endfunction

      function void acked();
         case (st)
            S_TX_DEV: begin
               if (cmd[3:2] == 2'd0) load_byte(S_TX_ALO, addr[7:0]);
               else load_byte(S_TX_AHI, addr[15:8]);
            end
            S_TX_AHI: load_byte(S_TX_ALO, addr[7:0]);
            S_TX_ALO: begin
               if (op_type'(cmd[1:0]) == OP_READ) st = S_RSTA_A;
               else next_data();
            end
            S_TX_DEVR: begin
               st = S_RX;
               bi = '0;
               ph = '0;
               sh = '0;
            end
            default: begin
               if (left > 0) left--;
               next_data();
            end
         endcase
      endfunction

      function void note(req_type r);
         rsp_type o;
         logic [17:0] c;
         bit bad;
         o = '0;
         if (r.action == ACT_START && st == S_IDLE) begin
            bad = r.op == OP_BAD || (r.kind == 2'd0 && r.cs != 0) ||
                  ((r.kind == 2'd1 || r.kind == 2'd2) && r.cs > 1);
            c = (r.cnt > MaxXfer) ? 18'(MaxXfer) : r.cnt;
            if (r.op == OP_READ && c == 0) begin
               o.done = 1'b1;
               o.status = ST_OK;
            end else if (bad) begin
               o.done = 1'b1;
               o.status = ST_BADDEV;
            end else begin
               cmd = {r.cs, r.kind, r.op};
               case (r.kind)
                  2'd0: addr = r.maddr & 17'h001FF;
                  2'd1: addr = r.maddr & 17'h01FFF;
                  2'd2: addr = r.maddr & 17'h07FFF;
                  default: addr = r.maddr;
               endcase
               left = c;
               fin = ST_OK;
               st = S_STA_A;
            end
         end else if (r.action == ACT_DATA && st == S_WAIT) begin
            load_byte(S_TX_DATA, r.wbyte);
         end else if (r.action == ACT_TICK) begin
            if (sending() || st == S_RX) begin
               if (ph == 0) begin
                  ph = 2'd1;
               end else if (bi < 8) begin
                  if (st == S_RX) begin
                     sh = {sh[6:0], r.sda};
                     if (bi == 7) begin
                        o.rvalid = 1'b1;
                        o.rbyte = sh;
                     end
                  end
                  bi++;
                  ph = '0;
               end else if (st == S_RX) begin
                  if (left > 0) left--;
                  if (left == 0) go_stop(ST_OK);
                  else begin
                     bi = '0;
                     ph = '0;
                     sh = '0;
                  end
               end else if (r.sda) begin
                  go_stop(ST_NACK);
               end else begin
                  acked();
               end
            end else if (st == S_STA_A || st == S_RSTA_A) begin
               if (!r.sda) go_stop(ST_BUSY);
               else st = seq_type'(st + 1);
            end else if (st == S_STA_B || st == S_RSTA_B) begin
               if (r.sda) go_stop(ST_BUSY);
               else st = seq_type'(st + 1);
            end else if (st == S_STA_C) begin
               load_byte(S_TX_DEV, device_byte(1'b0));
            end else if (st == S_RSTA_C) begin
               load_byte(S_TX_DEVR, device_byte(1'b1));
            end else if (st == S_STOP_0) begin
               st = S_STOP_1;
            end else if (st == S_STOP_1) begin
               st = S_IDLE;
               o.done = 1'b1;
               o.status = fin;
            end
         end
         if (sending()) begin
            scl_d = ph[0];
            sda_d = (bi < 8) ? sh[7 - bi] : 1'b1;
         end else if (st == S_RX) begin
            scl_d = ph[0];
            sda_d = (bi < 8) ? 1'b1 : (left <= 1);
         end else if (st == S_STA_B || st == S_RSTA_B || st == S_STOP_1) begin
            scl_d = 1'b1;
            sda_d = 1'b0;
         end else if (st == S_STA_C || st == S_RSTA_C || st == S_STOP_0) begin
            scl_d = 1'b0;
            sda_d = 1'b0;
         end else if (st == S_WAIT) begin
            scl_d = 1'b0;
            sda_d = 1'b1;
         end else begin
            scl_d = 1'b1;
            sda_d = 1'b1;
         end
         o.scl = scl_d;
         o.sda = sda_d;
         o.need = st == S_WAIT;
         o.busy = st != S_IDLE;
         expected_rsp.push_back(o);
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response transfer %h", a);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         checked++;
         if (a.rvalid) reads_seen++;
         if (a.done) done_seen++;
         if (a.scl !== e.scl) begin
            $error("scl: expected %0d actual %0d", e.scl, a.scl);
            errors++;
         end
         if (a.sda !== e.sda) begin
            $error("sda: expected %0d actual %0d", e.sda, a.sda);
            errors++;
         end
         if (a.rbyte !== e.rbyte) begin
            $error("rbyte: expected %h actual %h", e.rbyte, a.rbyte);
            errors++;
         end
         if (a.rvalid !== e.rvalid) begin
            $error("rvalid: expected %0d actual %0d", e.rvalid, a.rvalid);
            errors++;
         end
         if (a.need !== e.need) begin
            $error("need: expected %0d actual %0d", e.need, a.need);
            errors++;
         end
         if (a.busy !== e.busy) begin
            $error("busy: expected %0d actual %0d", e.busy, a.busy);
            errors++;
         end
         if (a.done !== e.done) begin
            $error("done: expected %0d actual %0d", e.done, a.done);
            errors++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ifm_stream_if #(.W($bits(req_type))) req_if ();
   ifm_stream_if #(.W($bits(rsp_type))) rsp_if ();

   i2c_fram_transaction_master_top dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   fram_scoreboard sb = new();
   int rsp_idle_pct;
   int hold_cycles;
   int noise_pct;
   int sent;
   int stall;
   fault_type fault;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) sb.check(rsp_if.data);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall <= 0;
      else
         stall <= stall + 1;
      if (stall >= StallLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic offer(req_type r);
      req_if.valid <= 1'b1;
      req_if.data <= r;
      do @(posedge clock); while (!req_if.ready);
      sb.note(r);
      sent++;
   endtask

   task automatic csr_write(logic [7:0] v);
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 2'd0;
      csr_pwdata <= {24'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.base = v;
   endtask

   function automatic req_type next_item();
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom});
      if ($urandom_range(0, 99) < noise_pct) begin
         if (r.action == ACT_START) r.cnt = 18'($urandom_range(0, 15));
         return r;
      end
      if (sb.st == S_IDLE) begin
         r.action = ACT_START;
         r.op = ($urandom_range(0, 99) < 92) ? op_type'($urandom_range(0, 2)) : OP_BAD;
         r.kind = $urandom_range(0, 3);
         if ($urandom_range(0, 99) < 8) r.cs = $urandom_range(0, 3);
         else if (r.kind == 2'd0) r.cs = 2'd0;
         else if (r.kind == 2'd3) r.cs = $urandom_range(0, 3);
         else r.cs = $urandom_range(0, 1);
         r.cnt = ($urandom_range(0, 99) < 6) ? $urandom_range(4, 12) : $urandom_range(0, 3);
         if ($urandom_range(0, 99) < 6) fault = FLT_BUSY;
         else if ($urandom_range(0, 99) < 8) fault = FLT_NACK;
         else fault = FLT_NONE;
      end else if (sb.st == S_WAIT) begin
         r.action = ($urandom_range(0, 99) < 95) ? ACT_DATA : ACT_TICK;
      end else begin
         r.action = ACT_TICK;
         if (sb.st == S_STA_A || sb.st == S_RSTA_A) begin
            r.sda = (fault == FLT_BUSY) ? 1'b0 : 1'b1;
            if (fault == FLT_BUSY) fault = FLT_NONE;
         end else if (sb.st == S_STA_B || sb.st == S_RSTA_B) begin
            r.sda = 1'b0;
         end else if (sb.sending() && sb.ph == 1 && sb.bi == 8) begin
            r.sda = (fault == FLT_NACK) ? 1'b1 : 1'b0;
            if (fault == FLT_NACK && $urandom_range(0, 1)) fault = FLT_NONE;
         end
      end
      return r;
   endfunction

   function automatic req_type command(op_type op, logic [1:0] kind, logic [1:0] cs,
                                       logic [16:0] maddr, logic [17:0] cnt);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom});
      r.action = ACT_START;
      r.op = op;
      r.kind = kind;
      r.cs = cs;
      r.maddr = maddr;
      r.cnt = cnt;
      return r;
   endfunction

   task automatic run_txn(req_type c, fault_type f);
      offer(c);
      fault = f;
      while (sb.st != S_IDLE) offer(next_item());
   endtask

   task automatic run_random(int n, int idle_pct);
      int target;
      target = sent + n;
      while (sent < target || sb.st != S_IDLE) begin
         offer(next_item());
         if ($urandom_range(0, 99) < idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
      req_if.valid <= 1'b0;
   endtask

   initial begin
      req_type r;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      rsp_idle_pct = 62;
      hold_cycles = 0;
      noise_pct = 0;
      sent = 0;
      fault = FLT_NONE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(command(OP_READ, 2'd0, 2'd3, 17'h1FFFF, 18'd0));
      offer(command(OP_WRITE, 2'd0, 2'd1, 17'h0, 18'd1));
      offer(command(OP_READ, 2'd1, 2'd2, 17'h0, 18'd1));
      offer(command(OP_BAD, 2'd3, 2'd0, 17'h0, 18'd1));
      run_txn(command(OP_WRITE, 2'd1, 2'd1, 17'h1FFFF, 18'd0), FLT_NONE);
      run_txn(command(OP_READ, 2'd3, 2'd3, 17'h1FFFF, 18'd2), FLT_NONE);
      run_txn(command(OP_ERASE, 2'd2, 2'd1, 17'h1FFFF, 18'd1), FLT_NONE);
      run_txn(command(OP_WRITE, 2'd3, 2'd2, 17'h0, 18'd1), FLT_BUSY);
      run_txn(command(OP_ERASE, 2'd3, 2'd0, 17'h10000, 18'h3FFFF), FLT_NACK);

      fault = FLT_NONE;
      offer(command(OP_WRITE, 2'd0, 2'd0, 17'h1FF, 18'd1));
      offer(command(OP_READ, 2'd1, 2'd0, 17'h0, 18'd0));
      r = next_item();
      r.action = ACT_DATA;
      offer(r);
      r.action = ACT_NONE;
      offer(r);
      while (sb.st != S_WAIT) offer(next_item());
      r = next_item();
      r.action = ACT_TICK;
      offer(r);
      r.action = ACT_DATA;
      r.wbyte = 8'hFF;
      offer(r);
      while (sb.st != S_IDLE) offer(next_item());
      req_if.valid <= 1'b0;

      noise_pct = 3;
      rsp_idle_pct = 62;
      run_random(150, 17);
      hold_cycles = 400;
      run_random(150, 0);

      csr_write(8'h00);
      rsp_idle_pct = 17;
      run_random(300, 62);

      csr_write(8'hFF);
      rsp_idle_pct = 0;
      run_random(150, 0);
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      run_random(150, 0);

      csr_write(8'($urandom));
      rsp_idle_pct = 0;
      run_random(200, 0);

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d request transfers, %0d responses checked", sent, sb.checked);
      $display("%0d transactions ended, %0d bytes read, 4 base settings",
               sb.done_seen, sb.reads_seen);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

@@ i2c_fram_transaction_master_top.f @@
rtl/core/ifm_pkg.sv
rtl/core/ifm_stream_if.sv
rtl/core/ifm_queue.sv
rtl/core/ifm_front.sv
rtl/core/ifm_engine.sv
rtl/core/i2c_fram_transaction_master_top.sv
verif/i2c_fram_transaction_master_top_tb.sv
